// ===== rtl/ucr_pkg.sv =====
// Shared types, constants and register map of the ultrasonic ranging controller.
package ucr_pkg;

  // Default width of the tick counters
  localparam int unsigned CountWidthDef = 16;

  // Field widths fixed by the register map and the result item
  localparam int unsigned TrigW  = 10;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned RangeW = 14;

  // Speed of sound scaling: mm = echo_ticks * 343 / 2000
  localparam int unsigned SoundNum = 343;
  localparam int unsigned SoundDen = 2000;
  localparam int unsigned RemW     = 11;   // holds a remainder below SoundDen

  // Register reset values
  localparam logic [TrigW-1:0]  TrigWidthRst = TrigW'(10);
  localparam logic [TimeW-1:0]  TimeoutRst   = TimeW'(35000);
  localparam logic [TimeW-1:0]  GuardRst     = TimeW'(50000);
  localparam logic [RangeW-1:0] MinRangeRst  = RangeW'(40);
  localparam logic [RangeW-1:0] MaxRangeRst  = RangeW'(3000);

  // APB address decode: register index sits above the byte offset
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_TRIG_WIDTH = 3'd0,
    REG_TIMEOUT    = 3'd1,
    REG_GUARD      = 3'd2,
    REG_MIN_RANGE  = 3'd3,
    REG_MAX_RANGE  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_GUARD = 2'd1,
    PH_TRIG  = 2'd2,
    PH_WAIT  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TrigW-1:0]  trigger_width_us;
    logic [TimeW-1:0]  echo_timeout_us;
    logic [TimeW-1:0]  guard_us;
    logic [RangeW-1:0] min_range_mm;
    logic [RangeW-1:0] max_range_mm;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } in_item_t;

  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              done_res;
    logic              valid_res;
    logic              timed_out;
    logic [RangeW-1:0] distance_mm;
  } out_item_t;

endpackage

// ===== rtl/ucr_cfg.sv =====
// APB register file holding the ranging configuration.
module ucr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ucr_pkg::AddrW-1:0]   paddr,
  input  logic [ucr_pkg::DataW-1:0]   pwdata,
  output logic [ucr_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output ucr_pkg::cfg_t               cfg_o
);
  import ucr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TRIG_WIDTH: cfg_d.trigger_width_us = pwdata[TrigW-1:0];
        REG_TIMEOUT:    cfg_d.echo_timeout_us  = pwdata[TimeW-1:0];
        REG_GUARD:      cfg_d.guard_us         = pwdata[TimeW-1:0];
        REG_MIN_RANGE:  cfg_d.min_range_mm     = pwdata[RangeW-1:0];
        REG_MAX_RANGE:  cfg_d.max_range_mm     = pwdata[RangeW-1:0];
        default: ;      // unmapped addresses drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_width_us <= TrigWidthRst;
      cfg_q.echo_timeout_us  <= TimeoutRst;
      cfg_q.guard_us         <= GuardRst;
      cfg_q.min_range_mm     <= MinRangeRst;
      cfg_q.max_range_mm     <= MaxRangeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_TRIG_WIDTH: prdata = DataW'(cfg_q.trigger_width_us);
      REG_TIMEOUT:    prdata = DataW'(cfg_q.echo_timeout_us);
      REG_GUARD:      prdata = DataW'(cfg_q.guard_us);
      REG_MIN_RANGE:  prdata = DataW'(cfg_q.min_range_mm);
      REG_MAX_RANGE:  prdata = DataW'(cfg_q.max_range_mm);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ucr_core.sv =====
// Ranging sequencer: guard, trigger and echo timing with running distance.
module ucr_core #(
  parameter int unsigned COUNT_WIDTH = ucr_pkg::CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ucr_pkg::in_item_t   item_i,
  input  ucr_pkg::cfg_t       cfg_i,
  output ucr_pkg::out_item_t  res_o
);
  import ucr_pkg::*;

  // Quotient stays below a quarter of the pulse count (343/2000 < 1/4)
  localparam int unsigned QW   = COUNT_WIDTH - 2;
  localparam int unsigned TW   = (COUNT_WIDTH > TimeW) ? COUNT_WIDTH : TimeW;
  localparam int unsigned CMPW = (QW > RangeW) ? QW : RangeW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] ptimer_q, ptimer_d;
  logic [COUNT_WIDTH-1:0] gtimer_q, gtimer_d;
  logic [COUNT_WIDTH-1:0] pulse_q, pulse_d;
  logic [QW-1:0]          quot_q, quot_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic                   echo_prev_q, rise_q, rise_d, measured_q, measured_d;

  logic                   guard_ok, finish, fell, in_range;
  logic [COUNT_WIDTH-1:0] ptimer_inc;
  logic [RemW:0]          rem_sum;

  assign ptimer_inc = (ptimer_q == CntMax) ? CntMax : ptimer_q + 1'b1;
  assign rem_sum    = {1'b0, rem_q} + (RemW+1)'(SoundNum);

  // Next state for one tick
  always_comb begin
    phase_d    = phase_q;
    ptimer_d   = ptimer_q;
    pulse_d    = pulse_q;
    quot_d     = quot_q;
    rem_d      = rem_q;
    rise_d     = rise_q;
    measured_d = measured_q;
    finish     = 1'b0;
    fell       = 1'b0;
    in_range   = 1'b0;
    res_o      = '0;

    gtimer_d = gtimer_q;
    if (measured_q && gtimer_q != CntMax) begin
      gtimer_d = gtimer_q + 1'b1;
    end
    guard_ok = (TW'(gtimer_d) >= TW'(cfg_i.guard_us)) || (gtimer_d == CntMax);

    case (phase_q)
      PH_IDLE: begin
        if (item_i.start_req) begin
          if (measured_q && !guard_ok) begin
            phase_d = PH_GUARD;
          end else begin
            phase_d  = PH_TRIG;
            ptimer_d = '0;
          end
        end
      end
      PH_GUARD: begin
        if (guard_ok) begin
          phase_d  = PH_TRIG;
          ptimer_d = '0;
        end
      end
      PH_TRIG: begin
        ptimer_d = ptimer_inc;
        if (ptimer_inc >= COUNT_WIDTH'(cfg_i.trigger_width_us)) begin
          phase_d  = PH_WAIT;
          ptimer_d = '0;
          rise_d   = 1'b0;
          pulse_d  = '0;
          quot_d   = '0;
          rem_d    = '0;
        end
      end
      PH_WAIT: begin
        ptimer_d = ptimer_inc;
        if (rise_q) begin
          // pulse count and its scaled distance advance together until saturation
          if (pulse_q != CntMax) begin
            pulse_d = pulse_q + 1'b1;
            if (rem_sum >= (RemW+1)'(SoundDen)) begin
              rem_d  = RemW'(rem_sum - (RemW+1)'(SoundDen));
              quot_d = quot_q + 1'b1;
            end else begin
              rem_d  = RemW'(rem_sum);
            end
          end
          if (!item_i.echo) begin
            finish = 1'b1;
            fell   = 1'b1;
          end
        end else if (item_i.echo && !echo_prev_q) begin
          rise_d  = 1'b1;
          pulse_d = '0;
          quot_d  = '0;
          rem_d   = '0;
        end
        if (!finish && ((TW'(ptimer_inc) >= TW'(cfg_i.echo_timeout_us)) ||
                        (ptimer_inc == CntMax))) begin
          finish = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // Cycle completion
    if (finish) begin
      res_o.done_res = 1'b1;
      if (fell) begin
        in_range = (CMPW'(quot_d) >= CMPW'(cfg_i.min_range_mm)) &&
                   (CMPW'(quot_d) <= CMPW'(cfg_i.max_range_mm));
        if (in_range) begin
          res_o.valid_res   = 1'b1;
          res_o.distance_mm = RangeW'(quot_d);
        end
      end else begin
        res_o.timed_out = 1'b1;
      end
      measured_d = 1'b1;
      gtimer_d   = '0;
      phase_d    = PH_IDLE;
      ptimer_d   = '0;
      rise_d     = 1'b0;
    end

    res_o.trigger  = (phase_d == PH_TRIG);
    res_o.busy_res = (phase_d != PH_IDLE);
  end

  // State registers advance once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ptimer_q    <= '0;
      gtimer_q    <= '0;
      pulse_q     <= '0;
      quot_q      <= '0;
      rem_q       <= '0;
      echo_prev_q <= 1'b0;
      rise_q      <= 1'b0;
      measured_q  <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      ptimer_q    <= ptimer_d;
      gtimer_q    <= gtimer_d;
      pulse_q     <= pulse_d;
      quot_q      <= quot_d;
      rem_q       <= rem_d;
      echo_prev_q <= item_i.echo;
      rise_q      <= rise_d;
      measured_q  <= measured_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A finishing tick always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |-> !res_o.busy_res && !res_o.trigger)
    else $error("cycle finished but sequencer not idle");

  // A valid distance only comes from an echo edge, never a timeout
  a_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid_res |-> res_o.done_res && !res_o.timed_out)
    else $error("valid distance without a clean echo finish");

  // Distance is zero unless reported valid
  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !res_o.valid_res |-> res_o.distance_mm == '0)
    else $error("distance driven while not valid");

  // Once a cycle has finished the guard stays armed
  a_measured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> measured_q && gtimer_q == '0)
    else $error("guard not restarted after cycle end");
`endif

endmodule

// ===== rtl/ultrasonic_ranging_controller.sv =====
// Ultrasonic echo-ranging controller: input/result registers around the sequencer.
//
// Usage: every input transaction is one microsecond tick carrying start_req and the
// sampled echo level. Every accepted tick yields exactly one result transaction with
// the trigger pin level, busy, the one-tick done pulse, valid/timed_out flags and
// the distance in millimetres (floor(echo_ticks * 343 / 2000), zero unless valid).
// Path: a tick is held in the input register, and its result is then held in the
// result register. Throughput: one tick per cycle while out_stall_i is low, set by
// the single-pass sequencer update between those two registers; a new tick is
// taken while a finished result waits downstream.
// Stall: while out_stall_i holds a pending result, the result register and the
// input register fill up and in_stall_o rises; no tick is dropped or repeated.
// Configuration goes through the APB port (registers at byte offsets 0..16); it is
// to be changed only while no tick is in flight, which the block does not enforce.
// Reset: both registers empty, sequencer idle, all timers clear, the guard disarmed
// until the first cycle has finished, configuration at its defaults.
module ultrasonic_ranging_controller #(
  parameter int unsigned COUNT_WIDTH = ucr_pkg::CountWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ucr_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ucr_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ucr_pkg::AddrW-1:0]  paddr,
  input  logic [ucr_pkg::DataW-1:0]  pwdata,
  output logic [ucr_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import ucr_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  out_item_t out_q, res;
  logic      in_vld_q, out_vld_q;
  logic      out_free, step, in_take;

  // Pipeline flow: result slot frees when empty or being taken
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  ucr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ucr_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
